FILE: sv/aupf_pkg.sv
// Shared types and constants for the asymmetric unit point filter.
// Used by the controller, the datapath and the top level.
package aupf_pkg;

	localparam int unsigned MAX_ATOMS  = 4096;
	localparam int unsigned COUNT_W    = 13;
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		COUNT_W'((MAX_ATOMS > 8191) ? 8191 : MAX_ATOMS);

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 18;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 112;

	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned DIV2_STEPS = 33;
	localparam int unsigned DIV1_STEPS = 17;
	localparam int unsigned CNT_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_H   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_V   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIHEDRAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSION  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMPROPER_S = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EPS_TOL    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COS_LIMIT  = 3'd7;

	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic init_a;
		logic step_sqrt;
		logic step_div2;
		logic init_b;
		logic step_b;
		logic compare;
		logic emit;
	} aupf_cmd_t;

	typedef struct packed {
		logic sector_run;
		logic out_busy;
	} aupf_status_t;

endpackage

FILE: sv/aupf_ctrl.sv
// Sequencer of the point filter: walks each item through squaring and the sum and,
// where the sector test runs, the bit-serial root and divisions and the final compare, then the result load.
module aupf_ctrl
	import aupf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  aupf_status_t status,
	output aupf_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_SQUARE, S_SUM, S_DECIDE, S_ITER_A, S_INIT_B, S_ITER_B, S_COMPARE, S_EMIT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SQUARE;
				end
				S_SQUARE: state_q <= S_SUM;
				S_SUM:    state_q <= S_DECIDE;
				S_DECIDE: begin
					cnt_q   <= '0;
					state_q <= status.sector_run ? S_ITER_A : S_EMIT;
				end
				S_ITER_A: begin
					if (cnt_q == CNT_W'(DIV2_STEPS - 1)) begin
						state_q <= S_INIT_B;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_INIT_B: begin
					cnt_q   <= '0;
					state_q <= S_ITER_B;
				end
				S_ITER_B: begin
					if (cnt_q == CNT_W'(DIV1_STEPS - 1)) begin
						state_q <= S_COMPARE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_COMPARE: state_q <= S_EMIT;
				S_EMIT: begin
					if (!status.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == S_IDLE);
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.square    = (state_q == S_SQUARE);
		cmd.sum       = (state_q == S_SUM);
		cmd.init_a    = (state_q == S_DECIDE);
		cmd.step_div2 = (state_q == S_ITER_A);
		cmd.step_sqrt = (state_q == S_ITER_A) && (cnt_q < CNT_W'(SQRT_STEPS));
		cmd.init_b    = (state_q == S_INIT_B);
		cmd.step_b    = (state_q == S_ITER_B);
		cmd.compare   = (state_q == S_COMPARE);
		cmd.emit      = (state_q == S_EMIT) && !status.out_busy;
	end

endmodule

FILE: sv/aupf_dp.sv
// Datapath of the point filter: configuration registers, coordinate
// registers, square/root/divide units, cut logic and the result register.
module aupf_dp
	import aupf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_last,
	input  aupf_cmd_t             cmd,
	output aupf_status_t          status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_keep,
	output logic                  out_last
);

	logic mirror_h_q, mirror_v_q, dihedral_q, inversion_q, improper_s_q;
	logic [5:0] fold_q;
	logic [15:0] eps_q;
	logic signed [17:0] cos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_h_q   <= 1'b0;
			mirror_v_q   <= 1'b0;
			dihedral_q   <= 1'b0;
			inversion_q  <= 1'b0;
			improper_s_q <= 1'b0;
			fold_q       <= 6'd1;
			eps_q        <= 16'd66;
			cos_q        <= -18'sd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIRROR_H:   mirror_h_q   <= cfg_data[0];
				REG_MIRROR_V:   mirror_v_q   <= cfg_data[0];
				REG_DIHEDRAL:   dihedral_q   <= cfg_data[0];
				REG_INVERSION:  inversion_q  <= cfg_data[0];
				REG_IMPROPER_S: improper_s_q <= cfg_data[0];
				REG_FOLD_COUNT: fold_q       <= cfg_data[5:0];
				REG_EPS_TOL:    eps_q        <= cfg_data[15:0];
				REG_COS_LIMIT:  cos_q        <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic last_q;
	logic [63:0] xsq_q, ysq_q, rr_q, n_q;
	logic [47:0] num_q;
	logic ca_lt_q;

	logic [COORD_W-1:0] ux, uy, uz;
	assign ux = x_q[31] ? (~x_q + 1'b1) : x_q;
	assign uy = y_q[31] ? (~y_q + 1'b1) : y_q;
	assign uz = z_q[31] ? (~z_q + 1'b1) : z_q;

	logic signed [32:0] eps_p, eps_n, xs, ys, zs;
	assign eps_p = $signed({17'b0, eps_q});
	assign eps_n = -eps_p;
	assign xs = $signed({x_q[31], x_q});
	assign ys = $signed({y_q[31], y_q});
	assign zs = $signed({z_q[31], z_q});

	logic x_lt, y_lt, y_gt, z_lt, z_gt;
	assign x_lt = xs < eps_n;
	assign y_lt = ys < eps_n;
	assign y_gt = ys > eps_p;
	assign z_lt = zs < eps_n;
	assign z_gt = zs > eps_p;

	logic [31:0] ee;
	logic rr_gt, fold_gt1, pre_keep;
	assign ee = 32'(eps_q) * 32'(eps_q);
	assign rr_gt = rr_q > {32'b0, ee};
	assign fold_gt1 = fold_q > 6'd1;

	always_comb begin
		priority if (mirror_h_q) pre_keep = !z_lt;
		else if (inversion_q) begin
			priority if (z_gt) pre_keep = 1'b1;
			else if (z_lt) pre_keep = 1'b0;
			else if (y_gt) pre_keep = 1'b1;
			else if (y_lt) pre_keep = 1'b0;
			else pre_keep = !x_lt;
		end else pre_keep = 1'b1;
	end

	// Bit-serial square root and the two restoring divisions.
	logic [63:0] sq_src_q;
	logic [35:0] sq_rem_q, sq_rem_sh, sq_trial;
	logic [31:0] root_q;
	logic [63:0] rem2_q;
	logic [64:0] rem2_sh;
	logic [32:0] q2_q, nlo_q;
	logic [47:0] rem1_q, dv_q;
	logic [16:0] q1_q;

	assign sq_rem_sh = {sq_rem_q[33:0], sq_src_q[63:62]};
	assign sq_trial  = {2'b0, root_q, 2'b01};
	assign rem2_sh   = {rem2_q, nlo_q[32]};

	logic signed [17:0] t1;
	logic signed [33:0] t2;
	logic signed [35:0] ca;
	assign t1 = x_q[31] ? -$signed({1'b0, q1_q}) : $signed({1'b0, q1_q});
	assign t2 = y_q[31] ? -$signed({1'b0, q2_q}) : $signed({1'b0, q2_q});
	assign ca = mirror_v_q ? (36'(t1) + 36'(t2)) : (36'(t1) - 36'(t2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= in_data[31:0];
			y_q     <= in_data[63:32];
			z_q     <= in_data[95:64];
			last_q  <= in_last;
			ca_lt_q <= 1'b0;
		end
		if (cmd.square) begin
			xsq_q <= 64'(ux) * 64'(ux);
			ysq_q <= 64'(uy) * 64'(uy);
			num_q <= 48'(eps_q) * 48'(uy);
		end
		if (cmd.sum) begin
			rr_q <= xsq_q + ysq_q;
			n_q  <= {num_q, 16'b0};
		end
		if (cmd.init_a) begin
			sq_src_q <= rr_q;
			sq_rem_q <= '0;
			root_q   <= '0;
			rem2_q   <= {33'b0, n_q[63:33]};
			nlo_q    <= n_q[32:0];
			q2_q     <= '0;
		end
		if (cmd.step_sqrt) begin
			sq_src_q <= {sq_src_q[61:0], 2'b00};
			if (sq_rem_sh >= sq_trial) begin
				sq_rem_q <= sq_rem_sh - sq_trial;
				root_q   <= {root_q[30:0], 1'b1};
			end else begin
				sq_rem_q <= sq_rem_sh;
				root_q   <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.step_div2) begin
			nlo_q <= {nlo_q[31:0], 1'b0};
			if (rem2_sh >= {1'b0, rr_q}) begin
				rem2_q <= 64'(rem2_sh - {1'b0, rr_q});
				q2_q   <= {q2_q[31:0], 1'b1};
			end else begin
				rem2_q <= rem2_sh[63:0];
				q2_q   <= {q2_q[31:0], 1'b0};
			end
		end
		if (cmd.init_b) begin
			rem1_q <= {ux, 16'b0};
			dv_q   <= {root_q, 16'b0};
			q1_q   <= '0;
		end
		if (cmd.step_b) begin
			dv_q <= {1'b0, dv_q[47:1]};
			if (rem1_q >= dv_q) begin
				rem1_q <= rem1_q - dv_q;
				q1_q   <= {q1_q[15:0], 1'b1};
			end else begin
				q1_q   <= {q1_q[15:0], 1'b0};
			end
		end
		if (cmd.compare) begin
			ca_lt_q <= ca < 36'(cos_q);
		end
	end

	assign status.sector_run = fold_gt1 && pre_keep && rr_gt && !y_lt;
	assign status.out_busy   = out_valid && !out_ready;

	logic keep_c;
	always_comb begin
		keep_c = pre_keep;
		if (fold_gt1) begin
			if (keep_c && rr_gt && (y_lt || ca_lt_q)) keep_c = 1'b0;
			if (dihedral_q && !z_gt && (z_lt || y_lt)) keep_c = 1'b0;
			if (improper_s_q && z_lt) keep_c = 1'b0;
		end
	end

	logic [COUNT_W-1:0] total_q, total_next;
	assign total_next = (keep_c && (total_q < COUNT_CAP)) ? total_q + 1'b1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			total_q   <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid <= 1'b1;
				total_q   <= last_q ? '0 : total_next;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_keep <= keep_c;
			out_last <= last_q;
			out_data <= {3'b0, total_next,
				(uz < 32'(eps_q)) ? 32'b0 : z_q,
				(uy < 32'(eps_q)) ? 32'b0 : y_q,
				(ux < 32'(eps_q)) ? 32'b0 : x_q};
		end
	end

endmodule

FILE: sv/asymmetric_unit_point_filter.sv
// Top level of the asymmetric unit point filter.
// Joins the sequencer (aupf_ctrl) and the datapath (aupf_dp); uses aupf_pkg.
//
// One atom is handled at a time. An item whose rotation-sector test runs
// has its result loaded after the squares, the sum and the decision, the
// bit-serial square root and the slope division, which run side by side,
// the setup and run of the cosine division, and one compare. Items that
// skip the sector test have their result loaded after the squares, the sum
// and the decision only. The result load waits while an earlier result
// is still stalled on the output. The next item is accepted in the cycle
// after the result is loaded, while that result may still wait in the
// output register. Configuration writes are always ready and apply on the
// next cycle.
module asymmetric_unit_point_filter
	import aupf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // x_in, y_in, z_in
	input  logic                  s_tlast,   // last_atom
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // x_out, y_out, z_out, kept_count
	output logic                  m_tuser,   // keep
	output logic                  m_tlast    // last_out
);

	aupf_cmd_t    cmd;
	aupf_status_t status;

	assign cfg_ready = 1'b1;

	aupf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	aupf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_keep  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

FILE: sv/aupf_checker.sv
// Port-level checks for the asymmetric unit point filter.
// Bound to the top level; uses aupf_pkg.
module aupf_checker
	import aupf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[108:96] <= COUNT_CAP)
		else $error("kept count above cap");

	a_keep_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[108:96] != '0)
		else $error("kept item with zero count");

endmodule

bind asymmetric_unit_point_filter aupf_checker u_aupf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
